// ===== hdl/vvs_pkg.sv =====
// Shared constants and types for the velocity Verlet step block.
`timescale 1ns / 1ps

package vvs_pkg;

	// Number of axes handled side by side: two linear, one rotational.
	localparam int NUM_AXES = 3;

	// Axis that a lane serves; the rotational axis gets the lever scaling.
	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_R = 2'd2
	} axis_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_TIME_STEP    = 2'd0,
		REG_BODY_MASS    = 2'd1,
		REG_LEVER_LENGTH = 2'd2
	} reg_index_t;

endpackage

// ===== hdl/vvs_div_step.sv =====
// One restoring division step: one quotient bit per pipeline stage.
`timescale 1ns / 1ps

module vvs_div_step #(
	parameter int WORD_WIDTH    = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic [WORD_WIDTH-1:0]                 divisor,
	input  logic [WORD_WIDTH-1:0]                 rem_in,
	input  logic [WORD_WIDTH+FRACTION_BITS-1:0]   num_in,
	input  logic [WORD_WIDTH+FRACTION_BITS-1:0]   quo_in,
	output logic [WORD_WIDTH-1:0]                 rem_out,
	output logic [WORD_WIDTH+FRACTION_BITS-1:0]   num_out,
	output logic [WORD_WIDTH+FRACTION_BITS-1:0]   quo_out
);

	localparam int W  = WORD_WIDTH;
	localparam int QB = WORD_WIDTH + FRACTION_BITS;

	logic [W:0]   trial;
	logic [W:0]   diff;
	logic         fits;

	// Shift the next numerator bit into the partial remainder and try the subtract.
	always_comb begin
		trial = {rem_in, num_in[QB-1]};
		diff  = trial - {1'b0, divisor};
		fits  = (trial >= {1'b0, divisor});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= fits ? diff[W-1:0] : trial[W-1:0];
			num_out <= {num_in[QB-2:0], 1'b0};
			quo_out <= {quo_in[QB-2:0], fits};
		end
	end

endmodule

// ===== hdl/vvs_lane.sv =====
// One axis lane: pipelined divide, lever scaling and the Verlet update.
`timescale 1ns / 1ps

module vvs_lane #(
	parameter int           WORD_WIDTH    = 32,
	parameter int           FRACTION_BITS = 16,
	parameter vvs_pkg::axis_t AXIS        = vvs_pkg::AXIS_X
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [WORD_WIDTH-1:0] time_step,
	input  logic [WORD_WIDTH-1:0] body_mass,
	input  logic [WORD_WIDTH-1:0] lever_length,
	input  logic [WORD_WIDTH-1:0] last_pos,
	input  logic [WORD_WIDTH-1:0] last_vel,
	input  logic [WORD_WIDTH-1:0] last_acc,
	input  logic [WORD_WIDTH-1:0] force_in,
	output logic [WORD_WIDTH-1:0] new_pos,
	output logic [WORD_WIDTH-1:0] new_vel,
	output logic [WORD_WIDTH-1:0] new_acc,
	output logic                  overflow
);

	localparam int W  = WORD_WIDTH;
	localparam int F  = FRACTION_BITS;
	localparam int QB = WORD_WIDTH + FRACTION_BITS;
	localparam int PW = 2 * WORD_WIDTH + 2;
	localparam int SIDE_W = 3 * WORD_WIDTH + 2;
	localparam logic ROT = (AXIS == vvs_pkg::AXIS_R);

	function automatic logic signed [PW-1:0] sx(input logic [W-1:0] a);
		return PW'(signed'(a));
	endfunction

	function automatic logic signed [PW-1:0] zx(input logic [W-1:0] a);
		return signed'(PW'(a));
	endfunction

	// Saturate a wide value to the word range; the top bit reports clipping.
	function automatic logic [W:0] sat(input logic signed [PW-1:0] v);
		logic         o;
		logic [W-1:0] r;
		o = (v[PW-1:W-1] != {(PW-W+1){v[PW-1]}});
		if (o) begin
			r = v[PW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end else begin
			r = v[W-1:0];
		end
		return {o, r};
	endfunction

	// Input stage: split the force into sign and magnitude for the divider.
	logic [W-1:0]      div_rem_s [QB+1];
	logic [QB-1:0]     div_num_s [QB+1];
	logic [QB-1:0]     div_quo_s [QB+1];
	logic [SIDE_W-1:0] side_s    [QB+1];
	logic [W-1:0]      force_mag;

	assign force_mag = force_in[W-1] ? (~force_in + W'(1)) : force_in;

	always_ff @(posedge clk) begin
		if (en) begin
			div_rem_s[0] <= '0;
			div_num_s[0] <= {force_mag, {F{1'b0}}};
			div_quo_s[0] <= '0;
			side_s[0]    <= {force_in == '0, force_in[W-1], last_acc, last_vel, last_pos};
		end
	end

	// Divider pipeline; the side word rides along with each step.
	for (genvar k = 0; k < QB; k++) begin : g_div
		vvs_div_step #(
			.WORD_WIDTH    (W),
			.FRACTION_BITS (F)
		) u_step (
			.clk     (clk),
			.en      (en),
			.divisor (body_mass),
			.rem_in  (div_rem_s[k]),
			.num_in  (div_num_s[k]),
			.quo_in  (div_quo_s[k]),
			.rem_out (div_rem_s[k+1]),
			.num_out (div_num_s[k+1]),
			.quo_out (div_quo_s[k+1])
		);

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
			end
		end
	end

	logic [W-1:0] dpos, dvel, dacc;
	logic         dneg, dzero;
	logic [QB-1:0] quo;

	assign {dzero, dneg, dacc, dvel, dpos} = side_s[QB];
	assign quo = div_quo_s[QB];

	// Stage 1: sign the quotient and saturate; zero mass clips by force sign.
	logic [W-1:0] acc_q1;
	logic         big_q1, ovf_q1;
	logic [W-1:0] na_s1, lx_s1, lv_s1, la_s1;
	logic         ovf_s1;

	always_comb begin
		big_q1 = (quo[QB-1:W-1] != '0);
		if (body_mass == '0) begin
			ovf_q1 = ~dzero;
			if (dzero) begin
				acc_q1 = '0;
			end else begin
				acc_q1 = dneg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			end
		end else if (dneg) begin
			ovf_q1 = big_q1 && (quo != (QB'(1) << (W - 1)));
			acc_q1 = ovf_q1 ? {1'b1, {(W-1){1'b0}}} : (~quo[W-1:0] + W'(1));
		end else begin
			ovf_q1 = big_q1;
			acc_q1 = ovf_q1 ? {1'b0, {(W-1){1'b1}}} : quo[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			na_s1  <= acc_q1;
			ovf_s1 <= ovf_q1;
			lx_s1  <= dpos;
			lv_s1  <= dvel;
			la_s1  <= dacc;
		end
	end

	// Stage 2: first lever product.
	logic signed [PW-1:0] prod_s2;
	logic [W-1:0]         na_s2, lx_s2, lv_s2, la_s2;
	logic                 ovf_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= sx(na_s1) * zx(lever_length);
			na_s2   <= na_s1;
			ovf_s2  <= ovf_s1;
			lx_s2   <= lx_s1;
			lv_s2   <= lv_s1;
			la_s2   <= la_s1;
		end
	end

	// Stage 3: scale back, then second lever product.
	logic [W:0]           lev1;
	logic signed [PW-1:0] prod_s3;
	logic [W-1:0]         na_s3, lx_s3, lv_s3, la_s3;
	logic                 ovf_s3;

	assign lev1 = sat(prod_s2 >>> F);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= sx(lev1[W-1:0]) * zx(lever_length);
			na_s3   <= na_s2;
			ovf_s3  <= ovf_s2 | (ROT & lev1[W]);
			lx_s3   <= lx_s2;
			lv_s3   <= lv_s2;
			la_s3   <= la_s2;
		end
	end

	// Stage 4: scale back and halve on the rotational axis.
	logic [W:0]           lev2;
	logic signed [PW-1:0] lev2_half;
	logic [W-1:0]         na_s4, lx_s4, lv_s4, la_s4;
	logic                 ovf_s4;

	assign lev2      = sat(prod_s3 >>> F);
	assign lev2_half = sx(lev2[W-1:0]) >>> 1;

	always_ff @(posedge clk) begin
		if (en) begin
			na_s4  <= ROT ? lev2_half[W-1:0] : na_s3;
			ovf_s4 <= ovf_s3 | (ROT & lev2[W]);
			lx_s4  <= lx_s3;
			lv_s4  <= lv_s3;
			la_s4  <= la_s3;
		end
	end

	// Stage 5: the three time step products.
	logic signed [PW-1:0] acc_mean;
	logic signed [PW-1:0] pv_s5, p1_s5, p2a_s5;
	logic [W-1:0]         na_s5, lx_s5, lv_s5;
	logic                 ovf_s5;

	assign acc_mean = (sx(la_s4) + sx(na_s4)) >>> 1;

	always_ff @(posedge clk) begin
		if (en) begin
			pv_s5  <= sx(acc_mean[W-1:0]) * zx(time_step);
			p1_s5  <= sx(lv_s4) * zx(time_step);
			p2a_s5 <= (sx(la_s4) >>> 1) * zx(time_step);
			na_s5  <= na_s4;
			ovf_s5 <= ovf_s4;
			lx_s5  <= lx_s4;
			lv_s5  <= lv_s4;
		end
	end

	// Stage 6: new velocity, first position term, second time step product.
	logic [W:0]           dv, vsum, t1, t2a;
	logic signed [PW-1:0] p2_s6;
	logic [W-1:0]         nv_s6, t1_s6, na_s6, lx_s6;
	logic                 ovf_s6;

	assign dv   = sat(pv_s5 >>> F);
	assign vsum = sat(sx(lv_s5) + sx(dv[W-1:0]));
	assign t1   = sat(p1_s5 >>> F);
	assign t2a  = sat(p2a_s5 >>> F);

	always_ff @(posedge clk) begin
		if (en) begin
			p2_s6  <= sx(t2a[W-1:0]) * zx(time_step);
			nv_s6  <= vsum[W-1:0];
			t1_s6  <= t1[W-1:0];
			na_s6  <= na_s5;
			lx_s6  <= lx_s5;
			ovf_s6 <= ovf_s5 | dv[W] | vsum[W] | t1[W] | t2a[W];
		end
	end

	// Stage 7: new position.
	logic [W:0] t2, psum;

	assign t2   = sat(p2_s6 >>> F);
	assign psum = sat(sx(lx_s6) + sx(t1_s6) + sx(t2[W-1:0]));

	always_ff @(posedge clk) begin
		if (en) begin
			new_pos  <= psum[W-1:0];
			new_vel  <= nv_s6;
			new_acc  <= na_s6;
			overflow <= ovf_s6 | t2[W] | psum[W];
		end
	end

endmodule

// ===== hdl/velocity_verlet_step.sv =====
// Top level of the velocity Verlet step: config registers, lanes, merge and output.
`timescale 1ns / 1ps

// Usage:
// A word on the slave stream carries previous position, velocity and
// acceleration and the new force for the x, y and rotational axes. The master
// stream returns one word per input word with new position, velocity and
// acceleration for the three axes and an overflow flag.
// Three lanes, one per axis, run side by side; a merge stage ORs their
// overflow flags and packs the output word.
// The restoring divider in each lane resolves one quotient bit per stage.
// Throughput is one word per cycle while no output word is held refused.
// Configuration writes take effect at once; write them only while the block
// is empty. Reset clears all valid flags and loads the default time step,
// mass and lever length.
// When the receiver stalls with a word held at the output, the whole pipeline
// freezes and s_axis_tready drops until the word is taken.

module velocity_verlet_step #(
	parameter int WORD_WIDTH    = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,

	// fields low to high: last_pos_x/y/r, last_vel_x/y/r, last_acc_x/y/r, force_x/y/r
	input  logic [((12*WORD_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,

	// fields low to high: new_pos_x/y/r, new_vel_x/y/r, new_acc_x/y/r, overflow
	output logic [((9*WORD_WIDTH+8)/8)*8-1:0]    m_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,

	input  logic                                 cfg_we,
	input  logic [1:0]                           cfg_addr,
	input  logic [WORD_WIDTH-1:0]                cfg_data
);

	localparam int W     = WORD_WIDTH;
	localparam int LAT   = WORD_WIDTH + FRACTION_BITS + 8;
	localparam int OUT_W = ((9*WORD_WIDTH+8)/8)*8;
	localparam int NA    = vvs_pkg::NUM_AXES;

	// Configuration registers.
	logic [W-1:0] time_step_q, body_mass_q, lever_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q    <= W'(66);
			body_mass_q    <= W'(1) << FRACTION_BITS;
			lever_length_q <= W'(1) << FRACTION_BITS;
		end else if (cfg_we) begin
			unique case (vvs_pkg::reg_index_t'(cfg_addr))
				vvs_pkg::REG_TIME_STEP:    time_step_q    <= cfg_data;
				vvs_pkg::REG_BODY_MASS:    body_mass_q    <= cfg_data;
				vvs_pkg::REG_LEVER_LENGTH: lever_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline advance: freeze only while a held word is refused.
	logic           adv;
	logic [LAT-1:0] vld_q;
	logic           out_valid_q;

	assign adv           = ~(out_valid_q & ~m_axis_tready);
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q       <= {vld_q[LAT-2:0], s_axis_tvalid};
			out_valid_q <= vld_q[LAT-1];
		end
	end

	// Lanes, one per axis.
	logic [W-1:0] pos_l [NA];
	logic [W-1:0] vel_l [NA];
	logic [W-1:0] acc_l [NA];
	logic [NA-1:0] ovf_l;

	for (genvar a = 0; a < NA; a++) begin : g_lane
		vvs_lane #(
			.WORD_WIDTH    (W),
			.FRACTION_BITS (FRACTION_BITS),
			.AXIS          (vvs_pkg::axis_t'(a))
		) u_lane (
			.clk          (clk),
			.en           (adv),
			.time_step    (time_step_q),
			.body_mass    (body_mass_q),
			.lever_length (lever_length_q),
			.last_pos     (s_axis_tdata[a*W +: W]),
			.last_vel     (s_axis_tdata[(3+a)*W +: W]),
			.last_acc     (s_axis_tdata[(6+a)*W +: W]),
			.force_in     (s_axis_tdata[(9+a)*W +: W]),
			.new_pos      (pos_l[a]),
			.new_vel      (vel_l[a]),
			.new_acc      (acc_l[a]),
			.overflow     (ovf_l[a])
		);
	end

	// Merge stage: pack the lanes and combine their overflow flags.
	logic [OUT_W-1:0] packed_word;
	logic [OUT_W-1:0] tdata_q;

	always_comb begin
		packed_word = '0;
		for (int a = 0; a < NA; a++) begin
			packed_word[a*W +: W]     = pos_l[a];
			packed_word[(3+a)*W +: W] = vel_l[a];
			packed_word[(6+a)*W +: W] = acc_l[a];
		end
		packed_word[9*W] = |ovf_l;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tdata_q <= packed_word;
		end
	end

	assign m_axis_tdata  = tdata_q;
	assign m_axis_tvalid = out_valid_q;

	// A word appears only when one reached the end of the lanes.
	a_out_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(vld_q[LAT-1]))
		else $error("output word without a word in the last lane stage");

	// An accepted input word enters the valid line.
	a_in_tracked: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> vld_q[0])
		else $error("accepted word not tracked");

	// A refused output word freezes the valid line.
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(vld_q))
		else $error("pipeline moved while output stalled");

	// A mass write lands in the mass register.
	a_mass_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_addr == vvs_pkg::REG_BODY_MASS) |=> body_mass_q == $past(cfg_data))
		else $error("mass register write lost");

endmodule

// ===== test/vvs_checker.sv =====
// Checker for the velocity Verlet step: predicts each output word and compares it.
`timescale 1ns / 1ps

module vvs_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [383:0] s_axis_tdata,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [295:0] m_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_addr,
	input  logic [31:0]  cfg_data,
	output int           fail_count,
	output int           pending_count
);

	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;

	logic [31:0] step_reg, mass_reg, lever_reg;
	logic [295:0] step_results[$];
	bit clip_seen;

	// Saturate to the signed word range and note any clipping.
	function automatic longint clip(longint v);
		if (v > Q_MAX) begin
			clip_seen = 1;
			return Q_MAX;
		end
		if (v < Q_MIN) begin
			clip_seen = 1;
			return Q_MIN;
		end
		return v;
	endfunction

	// Fixed-point product of a signed value and an unsigned word, floored.
	function automatic longint qmul(longint a, logic [31:0] b);
		longint p;
		p = a * longint'({32'd0, b});
		return clip(p >>> 16);
	endfunction

	// Force over mass, truncated toward zero; a zero mass saturates by sign.
	function automatic longint qdiv(longint f, logic [31:0] m);
		if (m == 0) begin
			if (f != 0)
				clip_seen = 1;
			return (f > 0) ? Q_MAX : (f < 0) ? Q_MIN : 0;
		end
		return clip((f * 65536) / longint'({32'd0, m}));
	endfunction

	// Work out the full output word for one input word.
	function automatic logic [295:0] verlet_step(logic [383:0] d);
		logic [295:0] r;
		longint lx, lv, la, f, na, nv, np, t1, t2;
		r = '0;
		clip_seen = 0;
		for (int ax = 0; ax < vvs_pkg::NUM_AXES; ax++) begin
			lx = longint'($signed(d[32*ax +: 32]));
			lv = longint'($signed(d[32*(3+ax) +: 32]));
			la = longint'($signed(d[32*(6+ax) +: 32]));
			f  = longint'($signed(d[32*(9+ax) +: 32]));
			na = qdiv(f, mass_reg);
			if (vvs_pkg::axis_t'(ax) == vvs_pkg::AXIS_R) begin
				na = qmul(na, lever_reg);
				na = qmul(na, lever_reg);
				na = na >>> 1;
			end
			nv = clip(lv + qmul((la + na) >>> 1, step_reg));
			t1 = qmul(lv, step_reg);
			t2 = qmul(qmul(la >>> 1, step_reg), step_reg);
			np = clip(lx + t1 + t2);
			r[32*ax +: 32]     = np[31:0];
			r[32*(3+ax) +: 32] = nv[31:0];
			r[32*(6+ax) +: 32] = na[31:0];
		end
		r[288] = clip_seen;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: mismatch on %s: got %h expected %h", $time, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending_count = 0;
	end

	// Track register writes, predict on input, compare on output.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_reg  <= 32'd66;
			mass_reg  <= 32'd65536;
			lever_reg <= 32'd65536;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					vvs_pkg::REG_TIME_STEP:    step_reg  <= cfg_data;
					vvs_pkg::REG_BODY_MASS:    mass_reg  <= cfg_data;
					vvs_pkg::REG_LEVER_LENGTH: lever_reg <= cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				step_results.push_back(verlet_step(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (step_results.size() == 0) begin
					report_mismatch("unexpected word", 32'd1, 32'd0);
				end else begin
					logic [295:0] want;
					want = step_results.pop_front();
					for (int i = 0; i < 9; i++)
						if (m_axis_tdata[32*i +: 32] !== want[32*i +: 32])
							report_mismatch($sformatf("field %0d", i),
								m_axis_tdata[32*i +: 32], want[32*i +: 32]);
					if (m_axis_tdata[288] !== want[288])
						report_mismatch("overflow", 32'(m_axis_tdata[288]),
							32'(want[288]));
				end
			end
			pending_count <= step_results.size();
		end
	end
endmodule

// ===== test/tb_top.sv =====
// Testbench top for the velocity Verlet step: stimulus, configuration and verdict.
`timescale 1ns / 1ps

module tb_top;

	localparam int LATENCY = 56;
	localparam int IDLE_LIMIT = 2000;

	logic clk = 0;
	logic arst_n = 0;
	logic [383:0] s_axis_tdata = '0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [295:0] m_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic cfg_we = 0;
	logic [1:0] cfg_addr = '0;
	logic [31:0] cfg_data = '0;
	int fail_count, pending_count;
	bit calm_tail = 0;
	int quiet_cycles = 0;

	always #1 clk = ~clk;

	velocity_verlet_step DUT (.*);

	vvs_checker checker_i (.*);

	// Random value with a bias toward the extremes of a signed word.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h0;
			3: return $urandom_range(0, 1) ? 32'hffffffff : 32'h1;
			4, 5: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
			default: return $urandom;
		endcase
	endfunction

	// Offer one word; valid stays high afterward unless a gap or a drain follows.
	task automatic send_word(logic [383:0] d);
		if (!calm_tail && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		s_axis_tdata <= d;
		s_axis_tvalid <= 1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random(int n);
		logic [383:0] d;
		for (int k = 0; k < n; k++) begin
			for (int i = 0; i < 12; i++)
				d[32*i +: 32] = pick_word();
			send_word(d);
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (pending_count != 0) @(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
	endtask

	task automatic write_reg(vvs_pkg::reg_index_t idx, logic [31:0] v);
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 0;
		@(negedge clk);
	endtask

	// Receiver stalls in random bursts, none in the last part of the run.
	always @(negedge clk) begin
		if (calm_tail || $urandom_range(0, 4) != 0)
			m_axis_tready <= 1;
		else begin
			m_axis_tready <= 0;
			repeat ($urandom_range(0, 12)) @(negedge clk);
		end
	end

	// Watchdog on cycles with no accepted word.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		logic [383:0] d;
		repeat (8) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Directed words at reset settings: zeros, extremes, signs.
		send_word('0);
		send_word({12{32'h7fffffff}});
		send_word({12{32'h80000000}});
		send_word({12{32'hffffffff}});
		send_word({12{32'h00000001}});
		for (int i = 0; i < 12; i++)
			d[32*i +: 32] = (i % 2) ? 32'h80000000 : 32'h7fffffff;
		send_word(d);
		send_word(~d);
		send_random(8);
		drain();

		// Zero mass and zero lever, the smallest nonzero time step.
		write_reg(vvs_pkg::REG_BODY_MASS, 32'd0);
		write_reg(vvs_pkg::REG_LEVER_LENGTH, 32'd0);
		write_reg(vvs_pkg::REG_TIME_STEP, 32'd1);
		send_word('0);
		send_word({12{32'h7fffffff}});
		send_word({12{32'h80000000}});
		send_random(5);
		drain();

		// Largest values of every register.
		write_reg(vvs_pkg::REG_BODY_MASS, 32'hffffffff);
		write_reg(vvs_pkg::REG_LEVER_LENGTH, 32'hffffffff);
		write_reg(vvs_pkg::REG_TIME_STEP, 32'hffffffff);
		send_random(40);
		drain();

		// Moderate settings, mass of one half.
		write_reg(vvs_pkg::REG_BODY_MASS, 32'h8000);
		write_reg(vvs_pkg::REG_LEVER_LENGTH, 32'h18000);
		write_reg(vvs_pkg::REG_TIME_STEP, 32'h1000);
		send_random(150);
		drain();

		write_reg(vvs_pkg::REG_BODY_MASS, $urandom_range(1, 32'h40000));
		write_reg(vvs_pkg::REG_LEVER_LENGTH, $urandom_range(0, 32'h40000));
		write_reg(vvs_pkg::REG_TIME_STEP, $urandom_range(1, 32'h20000));
		send_random(200);
		drain();

		write_reg(vvs_pkg::REG_BODY_MASS, 32'd65536);
		write_reg(vvs_pkg::REG_LEVER_LENGTH, 32'd65536);
		write_reg(vvs_pkg::REG_TIME_STEP, 32'd66);
		send_random(150);
		calm_tail = 1;
		send_random(100);
		drain();

		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
